// ===== rtl/rri_pkg.sv =====
// ----------------------------------------------------------------------------
// rri_pkg
// Shared types, widths and codes of the ray against rectangle intersection.
// ----------------------------------------------------------------------------
package rri_pkg;

  localparam int COMP_W    = 20;             // Q8.12 component
  localparam int VEC_W     = COMP_W + 1;     // component after subtract or negate
  localparam int PROD_W    = 2 * VEC_W;      // 2x2 minor product
  localparam int COF_W     = PROD_W + 1;     // minor difference
  localparam int SPLIT_W   = 21;             // low slice of a minor
  localparam int DET_W     = 64;
  localparam int MAG_W     = 63;
  localparam int EXT_W     = 20;
  localparam int CFG_W     = 60;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 12;
  localparam int Q_W       = 33;
  localparam int NUM_W     = MAG_W + FRAC_W;
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_W     = MAG_W + DIV_STEPS;
  localparam int LO_W      = 32;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int CMP_W     = MAG_W + EXT_W + 1;
  localparam int BND_SH    = 13;             // |num| * 8192
  localparam int SAT_SH    = 20;             // ad * 0x100001
  localparam int DIV_STG   = 6;              // first divider stage
  localparam int LAST_STG  = DIV_STG + DIV_STEPS - 1;
  localparam int NSTG      = LAST_STG + 1;

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_PARALLEL = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_U = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_V = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd4;

  localparam logic [CFG_W-1:0] CENTRE_RST = 60'd0;
  localparam logic [CFG_W-1:0] AXIS_U_RST = 60'd4096;
  localparam logic [CFG_W-1:0] AXIS_V_RST = 60'd4294967296;
  localparam logic [EXT_W-1:0] EXT_RST    = 20'd4096;

  localparam logic signed [31:0] NO_HIT_T = -32'sd4096;
  localparam logic signed [31:0] T_MAX    = 32'sh7FFFFFFF;
  localparam logic signed [31:0] T_MIN    = 32'sh80000000;

  typedef logic signed [VEC_W-1:0] comp_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] origin_x;
    logic signed [COMP_W-1:0] origin_y;
    logic signed [COMP_W-1:0] origin_z;
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] distance_t;
  } out_t;

  typedef struct packed {
    logic [1:0] status;
    logic       sat;
    logic       neg;
  } meta_t;

  function automatic comp_t cfg_comp(input logic [CFG_W-1:0] p, input int k);
    return VEC_W'($signed(p[k*COMP_W +: COMP_W]));
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [DET_W-1:0] x);
    logic signed [DET_W-1:0] n;
    n = -x;
    return x[DET_W-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/rri_det3.sv =====
// ----------------------------------------------------------------------------
// rri_det3
// Three stage pipelined 3x3 determinant of column vectors a, b, c.
// ----------------------------------------------------------------------------
module rri_det3 (
  input  logic                                clk,
  input  logic                                en,
  input  rri_pkg::comp_t                      a [3],
  input  rri_pkg::comp_t                      b [3],
  input  rri_pkg::comp_t                      c [3],
  output logic signed [rri_pkg::DET_W-1:0]    det
);

  logic signed [rri_pkg::PROD_W-1:0] p_r [6];
  rri_pkg::comp_t                    o_r [3];
  logic signed [rri_pkg::COF_W-1:0]  plo_r [3];
  logic signed [rri_pkg::COF_W-1:0]  phi_r [3];
  logic signed [rri_pkg::COF_W-1:0]  plo_nxt [3];
  logic signed [rri_pkg::COF_W-1:0]  phi_nxt [3];
  logic signed [rri_pkg::DET_W-1:0]  det_r;
  logic signed [rri_pkg::DET_W-1:0]  det_nxt;

  // minors
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= rri_pkg::PROD_W'(b[1]) * rri_pkg::PROD_W'(c[2]);
      p_r[1] <= rri_pkg::PROD_W'(b[2]) * rri_pkg::PROD_W'(c[1]);
      p_r[2] <= rri_pkg::PROD_W'(a[1]) * rri_pkg::PROD_W'(c[2]);
      p_r[3] <= rri_pkg::PROD_W'(a[2]) * rri_pkg::PROD_W'(c[1]);
      p_r[4] <= rri_pkg::PROD_W'(a[1]) * rri_pkg::PROD_W'(b[2]);
      p_r[5] <= rri_pkg::PROD_W'(a[2]) * rri_pkg::PROD_W'(b[1]);
      o_r[0] <= a[0];
      o_r[1] <= b[0];
      o_r[2] <= c[0];
    end
  end

  // minor times top element, minor split in two slices
  always_comb begin
    logic signed [rri_pkg::COF_W-1:0] cof;
    logic signed [rri_pkg::COF_W-1:0] lo;
    logic signed [rri_pkg::COF_W-1:0] hi;
    for (int k = 0; k < 3; k++) begin
      cof = rri_pkg::COF_W'(p_r[2*k]) - rri_pkg::COF_W'(p_r[2*k+1]);
      lo  = rri_pkg::COF_W'($signed({1'b0, cof[rri_pkg::SPLIT_W-1:0]}));
      hi  = rri_pkg::COF_W'($signed(cof[rri_pkg::COF_W-1:rri_pkg::SPLIT_W]));
      plo_nxt[k] = lo * rri_pkg::COF_W'(o_r[k]);
      phi_nxt[k] = hi * rri_pkg::COF_W'(o_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  always_comb begin
    logic signed [rri_pkg::DET_W-1:0] t [3];
    for (int k = 0; k < 3; k++) begin
      t[k] = (rri_pkg::DET_W'(phi_r[k]) <<< rri_pkg::SPLIT_W) + rri_pkg::DET_W'(plo_r[k]);
    end
    det_nxt = t[0] - t[1] + t[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= det_nxt;
    end
  end

  assign det = det_r;

endmodule

// ===== rtl/rri_div.sv =====
// ----------------------------------------------------------------------------
// rri_div
// Pipelined restoring divider, one quotient bit per stage: q = floor(at*4096/ad).
// ----------------------------------------------------------------------------
module rri_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rri_pkg::MAG_W-1:0]     at,
  input  logic [rri_pkg::MAG_W-1:0]     ad,
  input  rri_pkg::meta_t                meta_i,
  output logic [rri_pkg::Q_W-1:0]       q,
  output rri_pkg::meta_t                meta_o
);

  logic [rri_pkg::NUM_W-1:0] n_r   [rri_pkg::DIV_STEPS];
  logic [rri_pkg::Q_W-1:0]   q_r   [rri_pkg::DIV_STEPS];
  logic [rri_pkg::MAG_W-1:0] ad_r  [rri_pkg::DIV_STEPS];
  rri_pkg::meta_t            m_r   [rri_pkg::DIV_STEPS];

  for (genvar j = 0; j < rri_pkg::DIV_STEPS; j++) begin : g_step
    logic [rri_pkg::NUM_W-1:0] n_in;
    logic [rri_pkg::Q_W-1:0]   q_in;
    logic [rri_pkg::MAG_W-1:0] ad_in;
    rri_pkg::meta_t            m_in;
    logic [rri_pkg::DIV_W-1:0] dsh;
    logic [rri_pkg::DIV_W-1:0] diff;
    logic                      ge;

    if (j == 0) begin : g_first
      assign n_in  = {at, {rri_pkg::FRAC_W{1'b0}}};
      assign q_in  = '0;
      assign ad_in = ad;
      assign m_in  = meta_i;
    end else begin : g_next
      assign n_in  = n_r[j-1];
      assign q_in  = q_r[j-1];
      assign ad_in = ad_r[j-1];
      assign m_in  = m_r[j-1];
    end

    // divisor aligned to quotient bit DIV_STEPS-1-j
    assign dsh  = rri_pkg::DIV_W'(ad_in) << (rri_pkg::DIV_STEPS - 1 - j);
    assign ge   = rri_pkg::DIV_W'(n_in) >= dsh;
    assign diff = rri_pkg::DIV_W'(n_in) - dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j]  <= ge ? diff[rri_pkg::NUM_W-1:0] : n_in;
        q_r[j]  <= {q_in[rri_pkg::Q_W-2:0], ge};
        ad_r[j] <= ad_in;
        m_r[j]  <= m_in;
      end
    end
  end

  assign q      = q_r[rri_pkg::DIV_STEPS-1];
  assign meta_o = m_r[rri_pkg::DIV_STEPS-1];

endmodule

// ===== rtl/ray_rectangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_rectangle_intersect
// Ray against rectangle test by Cramer's rule, returning status and distance.
// ----------------------------------------------------------------------------
// One ray is accepted every cycle while in_ready is high; results leave in
// order. The quotient for t comes from the divider, which forms one of its 33
// quotient bits per pipeline stage, behind one input stage, three determinant
// stages and two bound check stages. A two entry output buffer lets the
// pipeline keep taking rays while a result waits; in_ready drops only when
// both entries are full. The rectangle registers are to be written through
// the cfg port only while no ray is in flight; the block does not check it.
module ray_rectangle_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rri_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rri_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [rri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rri_pkg::CFG_W-1:0]         cfg_wdata
);

  // configuration
  logic [rri_pkg::CFG_W-1:0] centre_r, axis_u_r, axis_v_r;
  logic [rri_pkg::EXT_W-1:0] width_r, length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= rri_pkg::CENTRE_RST;
      axis_u_r <= rri_pkg::AXIS_U_RST;
      axis_v_r <= rri_pkg::AXIS_V_RST;
      width_r  <= rri_pkg::EXT_RST;
      length_r <= rri_pkg::EXT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rri_pkg::CFG_CENTRE: centre_r <= cfg_wdata;
        rri_pkg::CFG_AXIS_U: axis_u_r <= cfg_wdata;
        rri_pkg::CFG_AXIS_V: axis_v_r <= cfg_wdata;
        rri_pkg::CFG_WIDTH:  width_r  <= cfg_wdata[rri_pkg::EXT_W-1:0];
        rri_pkg::CFG_LENGTH: length_r <= cfg_wdata[rri_pkg::EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                  adv;
  logic [rri_pkg::NSTG-1:0] v_r;
  logic [1:0]            cnt_r;
  logic                  push, pop;

  assign adv      = (cnt_r != 2'd2);
  assign in_ready = adv;
  assign push     = adv && v_r[rri_pkg::LAST_STG];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[rri_pkg::NSTG-2:0], in_valid};
    end
  end

  // stage 0: w = origin - centre, nd = -dir
  rri_pkg::comp_t w_r [3];
  rri_pkg::comp_t nd_r [3];
  rri_pkg::comp_t u_vec [3];
  rri_pkg::comp_t v_vec [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r[0]  <= rri_pkg::VEC_W'(in_data.origin_x) - rri_pkg::cfg_comp(centre_r, 0);
      w_r[1]  <= rri_pkg::VEC_W'(in_data.origin_y) - rri_pkg::cfg_comp(centre_r, 1);
      w_r[2]  <= rri_pkg::VEC_W'(in_data.origin_z) - rri_pkg::cfg_comp(centre_r, 2);
      nd_r[0] <= -rri_pkg::VEC_W'(in_data.dir_x);
      nd_r[1] <= -rri_pkg::VEC_W'(in_data.dir_y);
      nd_r[2] <= -rri_pkg::VEC_W'(in_data.dir_z);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_vec[k] = rri_pkg::cfg_comp(axis_u_r, k);
      v_vec[k] = rri_pkg::cfg_comp(axis_v_r, k);
    end
  end

  // stages 1..3: the four determinants
  logic signed [rri_pkg::DET_W-1:0] dm, dv, du, dt;

  rri_det3 u_det_m (.clk(clk), .en(adv), .a(u_vec), .b(v_vec), .c(nd_r), .det(dm));
  rri_det3 u_det_v (.clk(clk), .en(adv), .a(u_vec), .b(w_r),   .c(nd_r), .det(dv));
  rri_det3 u_det_u (.clk(clk), .en(adv), .a(w_r),   .b(v_vec), .c(nd_r), .det(du));
  rri_det3 u_det_t (.clk(clk), .en(adv), .a(u_vec), .b(v_vec), .c(w_r),  .det(dt));

  // stage 4: magnitudes and extent products
  logic [rri_pkg::MAG_W-1:0]          ad4_r, at4_r, adv4_r, adu4_r;
  logic [rri_pkg::EXT_W+rri_pkg::LO_W-1:0] ll4_r, wl4_r;
  logic [rri_pkg::EXT_W+rri_pkg::HI_W-1:0] lh4_r, wh4_r;
  logic                               zero4_r, neg4_r;
  logic [rri_pkg::MAG_W-1:0]          ad4_nxt;

  assign ad4_nxt = rri_pkg::mag(dm);

  always_ff @(posedge clk) begin
    if (adv) begin
      ad4_r   <= ad4_nxt;
      at4_r   <= rri_pkg::mag(dt);
      adv4_r  <= rri_pkg::mag(dv);
      adu4_r  <= rri_pkg::mag(du);
      ll4_r   <= (rri_pkg::EXT_W+rri_pkg::LO_W)'(length_r)
               * (rri_pkg::EXT_W+rri_pkg::LO_W)'(ad4_nxt[rri_pkg::LO_W-1:0]);
      lh4_r   <= (rri_pkg::EXT_W+rri_pkg::HI_W)'(length_r)
               * (rri_pkg::EXT_W+rri_pkg::HI_W)'(ad4_nxt[rri_pkg::MAG_W-1:rri_pkg::LO_W]);
      wl4_r   <= (rri_pkg::EXT_W+rri_pkg::LO_W)'(width_r)
               * (rri_pkg::EXT_W+rri_pkg::LO_W)'(ad4_nxt[rri_pkg::LO_W-1:0]);
      wh4_r   <= (rri_pkg::EXT_W+rri_pkg::HI_W)'(width_r)
               * (rri_pkg::EXT_W+rri_pkg::HI_W)'(ad4_nxt[rri_pkg::MAG_W-1:rri_pkg::LO_W]);
      zero4_r <= (dm == '0);
      neg4_r  <= dt[rri_pkg::DET_W-1] ^ dm[rri_pkg::DET_W-1];
    end
  end

  // stage 5: bound checks, saturation check, status
  rri_pkg::meta_t            meta5_r, meta5_nxt;
  logic [rri_pkg::MAG_W-1:0] at5_r, ad5_r;

  always_comb begin
    logic [rri_pkg::CMP_W-1:0] rhs_len, rhs_wid, lhs_v, lhs_u, sat_lim;
    logic                      out_v, out_u;
    rhs_len = (rri_pkg::CMP_W'(lh4_r) << rri_pkg::LO_W) + rri_pkg::CMP_W'(ll4_r);
    rhs_wid = (rri_pkg::CMP_W'(wh4_r) << rri_pkg::LO_W) + rri_pkg::CMP_W'(wl4_r);
    lhs_v   = rri_pkg::CMP_W'(adv4_r) << rri_pkg::BND_SH;
    lhs_u   = rri_pkg::CMP_W'(adu4_r) << rri_pkg::BND_SH;
    sat_lim = (rri_pkg::CMP_W'(ad4_r) << rri_pkg::SAT_SH) + rri_pkg::CMP_W'(ad4_r);
    out_v   = lhs_v > rhs_len;
    out_u   = lhs_u > rhs_wid;
    meta5_nxt.sat = rri_pkg::CMP_W'(at4_r) >= sat_lim;
    meta5_nxt.neg = neg4_r;
    if (zero4_r) begin
      meta5_nxt.status = rri_pkg::ST_PARALLEL;
    end else if (out_v || out_u) begin
      meta5_nxt.status = rri_pkg::ST_OUTSIDE;
    end else begin
      meta5_nxt.status = rri_pkg::ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta5_r <= meta5_nxt;
      at5_r   <= at4_r;
      ad5_r   <= ad4_r;
    end
  end

  // stages 6..38: quotient
  logic [rri_pkg::Q_W-1:0] q_d;
  rri_pkg::meta_t          meta_d;

  rri_div u_div (
    .clk    (clk),
    .en     (adv),
    .at     (at5_r),
    .ad     (ad5_r),
    .meta_i (meta5_r),
    .q      (q_d),
    .meta_o (meta_d)
  );

  // final result formatting
  rri_pkg::out_t res;

  always_comb begin
    logic [rri_pkg::Q_W-1:0] nq;
    nq = '0 - q_d;
    res.status = meta_d.status;
    if (meta_d.status != rri_pkg::ST_HIT) begin
      res.distance_t = rri_pkg::NO_HIT_T;
    end else if (meta_d.sat) begin
      res.distance_t = meta_d.neg ? rri_pkg::T_MIN : rri_pkg::T_MAX;
    end else if (meta_d.neg) begin
      res.distance_t = (q_d > 33'h080000000) ? rri_pkg::T_MIN : $signed(nq[31:0]);
    end else begin
      res.distance_t = (q_d > 33'h07FFFFFFF) ? rri_pkg::T_MAX : $signed(q_d[31:0]);
    end
  end

  // two entry output buffer
  rri_pkg::out_t buf_r [2];
  logic          wp_r, rp_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rp_r];

`ifndef SYNTH
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[rri_pkg::LAST_STG] && cnt_r == 2'd2 |=> cnt_r != 2'd3)
    else $error("result pushed into full buffer");

  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rri_pkg::ST_HIT |-> out_data.distance_t == rri_pkg::NO_HIT_T)
    else $error("miss beat carries a distance");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");
`endif

endmodule
